// ===== src/psieve_pkg.sv =====
// ----------------------------------------------------------------------------
// Prime sieve table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package psieve_pkg;

  localparam int unsigned NUM_W          = 12;
  localparam int unsigned MAX_NUMBER_DEF = 4095;

  typedef enum logic {
    CMD_BUILD = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABOVE   = 2'd1,
    ST_UNBUILT = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MARK,
    S_RESP
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_init;
    logic clr_step;
    logic scan_init;
    logic scan_rd;
    logic scan_next;
    logic mark_init;
    logic mark_step;
    logic set_built;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic composite;
    logic mark_done;
  } dp_stat_t;

endpackage

// ===== src/psieve_ctrl.sv =====
// ----------------------------------------------------------------------------
// Prime sieve controller
// Sequences the clear, scan and mark phases of a build and the query reply.
// ----------------------------------------------------------------------------
module psieve_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  command_i,
  input  psieve_pkg::dp_stat_t  stat_i,
  output psieve_pkg::ctrl_cmd_t cmd_o,
  output logic                  busy,
  output logic                  done_o,
  output logic                  cfg_ready_o
);
  import psieve_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          if (command_i == CMD_BUILD) begin
            cmd_o.clr_init = 1'b1;
            state_d        = S_CLEAR;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.scan_done) begin
          cmd_o.set_built = 1'b1;
          state_d         = S_RESP;
        end else begin
          cmd_o.scan_rd = 1'b1;
          state_d       = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.composite) begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN_RD;
        end else begin
          cmd_o.mark_init = 1'b1;
          state_d         = S_MARK;
        end
      end
      S_MARK: begin
        if (stat_i.mark_done) begin
          cmd_o.scan_next = 1'b1;
          state_d         = S_SCAN_RD;
        end else begin
          cmd_o.mark_step = 1'b1;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // a command word takes the idle cycle; the limit waits for the next one
  assign busy        = (state_q != S_IDLE);
  assign done_o      = (state_q == S_RESP);
  assign cfg_ready_o = (state_q == S_IDLE) & ~start;

endmodule

// ===== src/psieve_dp.sv =====
// ----------------------------------------------------------------------------
// Prime sieve datapath
// Limit register, built flag, sieve counters and the one-bit mark memory.
// ----------------------------------------------------------------------------
module psieve_dp #(
  parameter int unsigned MAX_NUMBER = psieve_pkg::MAX_NUMBER_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psieve_pkg::ctrl_cmd_t       cmd_i,
  output psieve_pkg::dp_stat_t        stat_o,
  input  logic                        command_i,
  input  logic [psieve_pkg::NUM_W-1:0] number_i,
  input  logic                        cfg_we_i,
  input  logic [psieve_pkg::NUM_W-1:0] cfg_data_i,
  output logic                        is_prime_o,
  output logic [1:0]                  status_o
);
  import psieve_pkg::*;

  localparam int unsigned DEPTH = MAX_NUMBER + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned W     = (AW > NUM_W) ? AW : NUM_W;

  logic [NUM_W-1:0] limit_q;
  logic             built_q;
  logic             query_q;
  status_e          status_q, status_d;

  logic [W-1:0]     lim_w, top, num_w;
  logic [W-1:0]     i_q;
  logic [W:0]       ptr_q, twice_i, top_x;

  // composite marks: 1 = not prime
  logic             marks_q [DEPTH];
  logic             rdata_q;
  logic [AW-1:0]    raddr, waddr;
  logic             we, wdata, re;

  assign lim_w   = W'(limit_q);
  assign top     = (lim_w > W'(MAX_NUMBER)) ? W'(MAX_NUMBER) : lim_w;
  assign top_x   = {1'b0, top};
  assign num_w   = W'(number_i);
  assign twice_i = {i_q, 1'b0};

  always_comb begin
    if (command_i == CMD_BUILD) begin
      status_d = ST_OK;
    end else if (!built_q) begin
      status_d = ST_UNBUILT;
    end else if (num_w > top) begin
      status_d = ST_ABOVE;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      built_q <= 1'b0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_data_i;
      built_q <= 1'b0;
    end else if (cmd_i.set_built) begin
      built_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      query_q  <= (command_i == CMD_QUERY);
      status_q <= status_d;
    end
    if (cmd_i.clr_init) begin
      ptr_q <= '0;
    end else if (cmd_i.clr_step) begin
      ptr_q <= ptr_q + (W+1)'(1);
    end else if (cmd_i.mark_init) begin
      ptr_q <= twice_i;
    end else if (cmd_i.mark_step) begin
      ptr_q <= ptr_q + {1'b0, i_q};
    end
    if (cmd_i.scan_init) begin
      i_q <= W'(2);
    end else if (cmd_i.scan_next) begin
      i_q <= i_q + W'(1);
    end
  end

  // clear pass writes 0 and 1 as composite, the rest as unmarked
  assign we    = cmd_i.clr_step | cmd_i.mark_step;
  assign waddr = ptr_q[AW-1:0];
  assign wdata = cmd_i.mark_step | (ptr_q < (W+1)'(2));
  assign re    = cmd_i.scan_rd | cmd_i.accept;
  assign raddr = cmd_i.scan_rd ? i_q[AW-1:0] : num_w[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      marks_q[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= marks_q[raddr];
    end
  end

  assign stat_o.clr_last  = (ptr_q == top_x);
  assign stat_o.scan_done = (twice_i > top_x);
  assign stat_o.composite = rdata_q;
  assign stat_o.mark_done = (ptr_q > top_x);

  assign is_prime_o = query_q & (status_q == ST_OK) & ~rdata_q;
  assign status_o   = status_q;

endmodule

// ===== src/prime_sieve_table_top.sv =====
// Query: done_o is high in the cycle after start is taken; busy for 1 cycle, no new start while busy.
// Build: clears entries 0..top (top = limit capped at MAX_NUMBER), then reads each candidate
//   i with 2*i <= top and, for each prime, marks its multiples from 2*i up to top, then responds.
// Reset clears the limit and the built flag; table contents stay undefined.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Prime sieve table top level
// Sieve of Eratosthenes engine with build and query commands.
// ----------------------------------------------------------------------------
module prime_sieve_table_top #(
  parameter int unsigned MAX_NUMBER = psieve_pkg::MAX_NUMBER_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [psieve_pkg::NUM_W-1:0] number_i,
  output logic                        done_o,
  output logic                        is_prime_o,
  output logic [1:0]                  status_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [psieve_pkg::NUM_W-1:0] cfg_data_i
);
  import psieve_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      cfg_we;

  assign cfg_we = cfg_valid_i & cfg_ready_o;

  psieve_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .command_i   (command_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy),
    .done_o      (done_o),
    .cfg_ready_o (cfg_ready_o)
  );

  psieve_dp #(
    .MAX_NUMBER (MAX_NUMBER)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .command_i  (command_i),
    .number_i   (number_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .is_prime_o (is_prime_o),
    .status_o   (status_o)
  );

endmodule
